// ----- rtl/sdr_pkg.sv -----
`default_nettype none

package sdr_pkg;

  // Operand width and the width of the step counter.
  localparam int unsigned Width = 32;
  localparam int unsigned CntW  = $clog2(Width);

  // Last step index; the counter runs from here down to zero.
  localparam logic [CntW-1:0] LastStep = CntW'(Width - 1);

  // Controls broadcast to every cell of the divider row.
  typedef struct packed {
    logic load;  // take new operand bits
    logic step;  // perform one shift-subtract step
    logic take;  // trial subtraction succeeded, keep the difference
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/sdr_cell.sv -----
`default_nettype none

module sdr_cell (
  input  wire                 clk_i,
  input  sdr_pkg::cell_ctrl_t ctrl_i,
  input  wire                 ld_quo_i,
  input  wire                 ld_den_i,
  input  wire                 rem_in_i,
  input  wire                 quo_in_i,
  input  wire                 borrow_i,
  output logic                borrow_o,
  output logic                rem_o,
  output logic                quo_o
);

  logic rem_q;
  logic quo_q;
  logic den_q;
  logic diff;

  // One bit of the trial subtraction of the divisor from the shifted remainder.
  assign diff     = rem_in_i ^ den_q ^ borrow_i;
  assign borrow_o = (~rem_in_i & den_q) | (~(rem_in_i ^ den_q) & borrow_i);

  // Load operand bits, or shift in from the lower neighbor and keep or drop the difference.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q <= 1'b0;
      quo_q <= ld_quo_i;
      den_q <= ld_den_i;
    end else if (ctrl_i.step) begin
      rem_q <= ctrl_i.take ? diff : rem_in_i;
      quo_q <= quo_in_i;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

`default_nettype wire

// ----- rtl/signed_divide_remainder_unit.sv -----
`default_nettype none

// Signed 32-bit divider giving the quotient truncated toward zero and the
// remainder with the sign of the dividend. The magnitudes are divided by
// restoring shift-subtract in a row of 32 bit-slice cells, one quotient bit
// per cycle, followed by a sign-correction state. A new request is accepted
// only while the sequencer is idle, once the previous request has passed
// through the 32 divide steps of the cell row and its sign correction. A
// stalled result is held in the output register and delays only the sign
// correction of the next request. A zero divisor gives zero quotient and
// remainder with divide_by_zero_o set; the most negative value divided by
// minus one wraps to the most negative value with a zero remainder.
module signed_divide_remainder_unit (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire signed [31:0]  dividend_i,
  input  wire signed [31:0]  divisor_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [31:0] quotient_o,
  output logic signed [31:0] remainder_o,
  output logic               divide_by_zero_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX
  } state_e;

  state_e                      state_q;
  logic [sdr_pkg::CntW-1:0]    cnt_q;
  logic                        a_neg_q;
  logic                        b_neg_q;
  logic                        dz_q;
  logic                        out_valid_q;
  logic [sdr_pkg::Width-1:0]   quo_out_q;
  logic [sdr_pkg::Width-1:0]   rem_out_q;
  logic                        dz_out_q;

  logic                        in_accept;
  logic                        fix_go;
  logic [sdr_pkg::Width-1:0]   a_mag;
  logic [sdr_pkg::Width-1:0]   b_mag;
  logic [sdr_pkg::Width-1:0]   rem_bits;
  logic [sdr_pkg::Width-1:0]   quo_bits;
  logic [sdr_pkg::Width-1:0]   rem_shift;
  logic [sdr_pkg::Width-1:0]   quo_shift;
  logic [sdr_pkg::Width:0]     borrow;
  logic [sdr_pkg::Width-1:0]   quo_fix;
  logic [sdr_pkg::Width-1:0]   rem_fix;
  sdr_pkg::cell_ctrl_t         ctrl;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign fix_go     = (state_q == ST_FIX) && (!out_valid_q || !out_stall_i);

  // Operand magnitudes for loading the cell row.
  assign a_mag = dividend_i[31] ? (~dividend_i + 32'd1) : dividend_i;
  assign b_mag = divisor_i[31]  ? (~divisor_i + 32'd1)  : divisor_i;

  // Shift paths between neighbors: remainder takes the top quotient bit at the bottom.
  assign rem_shift = {rem_bits[sdr_pkg::Width-2:0], quo_bits[sdr_pkg::Width-1]};
  assign quo_shift = {quo_bits[sdr_pkg::Width-2:0], ctrl.take};
  assign borrow[0] = 1'b0;

  // Subtraction succeeds when the shifted-out remainder bit is set or no borrow remains.
  assign ctrl.load = in_accept;
  assign ctrl.step = (state_q == ST_RUN);
  assign ctrl.take = rem_bits[sdr_pkg::Width-1] | ~borrow[sdr_pkg::Width];

  // Row of bit-slice cells.
  for (genvar i = 0; i < sdr_pkg::Width; i++) begin : g_cell
    sdr_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .ld_quo_i (a_mag[i]),
      .ld_den_i (b_mag[i]),
      .rem_in_i (rem_shift[i]),
      .quo_in_i (quo_shift[i]),
      .borrow_i (borrow[i]),
      .borrow_o (borrow[i+1]),
      .rem_o    (rem_bits[i]),
      .quo_o    (quo_bits[i])
    );
  end

  // Sign correction of the unsigned results.
  assign quo_fix = (a_neg_q ^ b_neg_q) ? (~quo_bits + 32'd1) : quo_bits;
  assign rem_fix = a_neg_q ? (~rem_bits + 32'd1) : rem_bits;

  // Sequencer, operand signs and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      a_neg_q     <= 1'b0;
      b_neg_q     <= 1'b0;
      dz_q        <= 1'b0;
      out_valid_q <= 1'b0;
      quo_out_q   <= '0;
      rem_out_q   <= '0;
      dz_out_q    <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            state_q <= ST_RUN;
            cnt_q   <= sdr_pkg::LastStep;
            a_neg_q <= dividend_i[31];
            b_neg_q <= divisor_i[31];
            dz_q    <= (divisor_i == 32'sd0);
          end
        end
        ST_RUN: begin
          if (cnt_q == '0) begin
            state_q <= ST_FIX;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_FIX: begin
          if (fix_go) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            quo_out_q   <= dz_q ? '0 : quo_fix;
            rem_out_q   <= dz_q ? '0 : rem_fix;
            dz_out_q    <= dz_q;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign quotient_o       = quo_out_q;
  assign remainder_o      = rem_out_q;
  assign divide_by_zero_o = dz_out_q;

`ifndef SYNTHESIS
  // A flagged division by zero reports zero results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> quotient_o == 32'sd0 && remainder_o == 32'sd0)
    else $error("divide by zero result not cleared");

  // An accepted request starts the step sequence from the last step index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_RUN && cnt_q == sdr_pkg::LastStep)
    else $error("step sequence not started on request");

  // A new result only appears out of the sign-correction cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIX))
    else $error("result presented without sign correction");
`endif

endmodule

`default_nettype wire
